>>> rtl/sfr_pkg.sv
// ---------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stream find-and-replace unit.
// ---------------------------------------------------------------------------
package sfr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_REPLACE = 8;
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 4;   // holds 0..8
  localparam int IDX_W       = 3;   // indexes 0..7
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LEN   = 2'd0,
    CFG_PATTERN_BYTES = 2'd1,
    CFG_REPLACE_LEN   = 2'd2,
    CFG_REPLACE_BYTES = 2'd3
  } cfg_idx_t;

  // input item kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // source of an emitted byte
  typedef enum logic {
    SRC_HELD = 1'b0,
    SRC_REP  = 1'b1
  } emit_src_t;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             calc;
    logic             emit;
    emit_src_t        src;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             compact;
  } sfr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] held_emit;
    logic [CNT_W-1:0] rep_emit;
    logic             out_free;
  } sfr_stat_t;

endpackage

>>> rtl/sfr_datapath.sv
// ---------------------------------------------------------------------------
// sfr_datapath
// Config registers, hold buffer, suffix/prefix match and output register.
// ---------------------------------------------------------------------------
module sfr_datapath import sfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sfr_cmd_t              cmd,
  output sfr_stat_t             stat,
  input  logic                  in_kind,
  input  logic [BYTE_W-1:0]     in_byte,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [BYTE_W-1:0]     out_tdata,
  output logic                  out_tlast
);

  // configuration
  logic [CNT_W-1:0]      plen_r;
  logic [CFG_DATA_W-1:0] pat_r;
  logic [CNT_W-1:0]      rlen_r;
  logic [CFG_DATA_W-1:0] rep_r;

  // hold buffer and per-item bookkeeping
  logic [BYTE_W-1:0] seq_r   [MAX_PATTERN];
  logic [BYTE_W-1:0] seq_nxt [MAX_PATTERN];
  logic [IDX_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  len_r;
  logic              pass_r;
  logic [CNT_W-1:0]  held_emit_r;
  logic [CNT_W-1:0]  rep_emit_r;
  logic [IDX_W-1:0]  keep_r;

  // output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  // match search signals
  logic [CNT_W-1:0]  eff_plen;
  logic [CNT_W-1:0]  eff_rlen;
  logic [BYTE_W-1:0] tail [MAX_PATTERN];
  logic [MAX_PATTERN:0] ok_v;
  logic [CNT_W-1:0]  k_sel;
  logic              match_full;
  logic [CNT_W-1:0]  held_emit_nxt;
  logic [CNT_W-1:0]  rep_emit_nxt;
  logic [IDX_W-1:0]  keep_nxt;
  logic              pass_nxt;
  logic [CNT_W-1:0]  len_nxt;
  logic [BYTE_W-1:0] emit_byte;

  // saturated lengths
  assign eff_plen = (plen_r > CNT_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN) : plen_r;
  assign eff_rlen = (rlen_r > CNT_W'(MAX_REPLACE)) ? CNT_W'(MAX_REPLACE) : rlen_r;

  // buffer viewed from its newest byte backwards
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      logic [CNT_W-1:0] tidx;
      tidx    = len_r - CNT_W'(j + 1);
      tail[j] = seq_r[tidx[IDX_W-1:0]];
    end
  end

  // longest buffer suffix that is a pattern prefix
  always_comb begin
    ok_v[0] = 1'b1;
    for (int k = 1; k <= MAX_PATTERN; k++) begin
      ok_v[k] = (CNT_W'(k) <= len_r) && (CNT_W'(k) <= eff_plen);
      for (int i = 0; i < k; i++) begin
        if (tail[k-1-i] != pat_r[i*BYTE_W +: BYTE_W]) begin
          ok_v[k] = 1'b0;
        end
      end
    end
    k_sel = '0;
    for (int k = 1; k <= MAX_PATTERN; k++) begin
      if (ok_v[k]) begin
        k_sel = CNT_W'(k);
      end
    end
  end

  assign match_full = (k_sel == eff_plen);

  // emit counts for this item
  always_comb begin
    if (pass_r) begin
      held_emit_nxt = len_r;
      rep_emit_nxt  = '0;
      keep_nxt      = '0;
    end else begin
      held_emit_nxt = len_r - k_sel;
      rep_emit_nxt  = match_full ? eff_rlen : '0;
      keep_nxt      = match_full ? '0 : k_sel[IDX_W-1:0];
    end
  end

  // item load decode
  assign pass_nxt = (in_kind == KIND_FLUSH) || (in_byte == NEWLINE) || (plen_r == '0);
  assign len_nxt  = (in_kind == KIND_FLUSH) ? {1'b0, cnt_r} : {1'b0, cnt_r} + CNT_W'(1);

  // hold buffer next value: new byte on load, shift kept bytes to front on compact
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      logic [CNT_W-1:0] src;
      src        = CNT_W'(i) + held_emit_r;
      seq_nxt[i] = seq_r[i];
      if (cmd.load && (in_kind == KIND_DATA) && (cnt_r == IDX_W'(i))) begin
        seq_nxt[i] = in_byte;
      end else if (cmd.compact && (src < CNT_W'(MAX_PATTERN))) begin
        seq_nxt[i] = seq_r[src[IDX_W-1:0]];
      end
    end
  end

  // byte to emit
  assign emit_byte = (cmd.src == SRC_HELD) ? seq_r[cmd.idx]
                                           : rep_r[{cmd.idx, 3'b000} +: BYTE_W];

  // payload registers
  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
    if (cmd.load) begin
      len_r  <= len_nxt;
      pass_r <= pass_nxt;
    end
    if (cmd.calc) begin
      held_emit_r <= held_emit_nxt;
      rep_emit_r  <= rep_emit_nxt;
      keep_r      <= keep_nxt;
    end
    if (cmd.emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= cmd.last;
    end
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r      <= '0;
      pat_r       <= '0;
      rlen_r      <= '0;
      rep_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PATTERN_LEN:   plen_r <= cfg_data[CNT_W-1:0];
          CFG_PATTERN_BYTES: pat_r  <= cfg_data;
          CFG_REPLACE_LEN:   rlen_r <= cfg_data[CNT_W-1:0];
          CFG_REPLACE_BYTES: rep_r  <= cfg_data;
          default:           plen_r <= plen_r;
        endcase
        cnt_r <= '0;
      end else if (cmd.compact) begin
        cnt_r <= keep_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.held_emit = held_emit_r;
  assign stat.rep_emit  = rep_emit_r;
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/sfr_ctrl.sv
// ---------------------------------------------------------------------------
// sfr_ctrl
// Sequencer: load an item, search, emit held then replacement bytes, compact.
// ---------------------------------------------------------------------------
module sfr_ctrl import sfr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  sfr_stat_t stat,
  output sfr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT_HELD,
    ST_EMIT_REP,
    ST_COMPACT
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             held_last;
  logic             rep_last;

  assign held_last = ({1'b0, idx_r} == (stat.held_emit - CNT_W'(1)));
  assign rep_last  = ({1'b0, idx_r} == (stat.rep_emit - CNT_W'(1)));

  assign in_tready = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cmd         = '0;
    cmd.idx     = idx_r;
    cmd.src     = SRC_HELD;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        idx_nxt   = '0;
        state_nxt = ST_EMIT_HELD;
      end
      ST_EMIT_HELD: begin
        if (stat.held_emit == '0) begin
          state_nxt = ST_EMIT_REP;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = held_last && (stat.rep_emit == '0);
          if (held_last) begin
            idx_nxt   = '0;
            state_nxt = ST_EMIT_REP;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      ST_EMIT_REP: begin
        cmd.src = SRC_REP;
        if (stat.rep_emit == '0) begin
          state_nxt = ST_COMPACT;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = rep_last;
          if (rep_last) begin
            state_nxt = ST_COMPACT;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      ST_COMPACT: begin
        cmd.compact = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

>>> rtl/stream_find_replace_unit.sv
// Sequence: an item is taken in ST_IDLE and searched in ST_CALC in the next cycle; its
//   first result is registered in ST_EMIT_HELD, or ST_EMIT_REP if it has no held bytes.
// Throughput: one item at a time; the sequencer writes one byte per cycle while the
//   output is free, held bytes then replacement bytes, then compacts the buffer.
// Reset: synchronous active-low rst_n clears config, held count and output valid.
// ---------------------------------------------------------------------------
// stream_find_replace_unit
// Streaming find-and-replace of a configured byte pattern, line by line.
// ---------------------------------------------------------------------------
module stream_find_replace_unit import sfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] in_byte
  input  logic                  in_tuser,   // [0] kind (1 = flush)
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [BYTE_W-1:0]     out_tdata,  // [7:0] out_byte
  output logic                  out_tlast,  // last_of_run
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sfr_cmd_t  cmd;
  sfr_stat_t stat;

  assign cfg_ready = 1'b1;

  // sequencer
  sfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  sfr_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_kind    (in_tuser),
    .in_byte    (in_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> rtl/sfr_checker.sv
// ---------------------------------------------------------------------------
// sfr_checker
// Port-level checks on the stream find-and-replace unit.
// ---------------------------------------------------------------------------
module sfr_checker import sfr_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [BYTE_W-1:0]     out_tdata,
  input logic                  out_tlast
);

  // stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result payload changed while stalled");

  // an accepted item blocks input through load and search
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("item taken while previous item in work");

  // reset leaves the unit ready with no pending result
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("unit not idle after reset");

endmodule

bind stream_find_replace_unit sfr_checker u_sfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
